### rtl/sd_spi_command_engine_defines.svh
// Assertion macros for the SD SPI command engine.
// Each use stands on a line of its own and ends the statement itself.
`ifndef SD_SPI_COMMAND_ENGINE_DEFINES_SVH
`define SD_SPI_COMMAND_ENGINE_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define SDSPI_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("sdspi: assertion failed");

`define SDSPI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sdspi: assertion failed one cycle on");

`else

`define SDSPI_ASSERT(lbl, prop)
`define SDSPI_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

### rtl/sdspi_pkg.sv
package sdspi_pkg;

  localparam int unsigned BLOCK_BYTES = 512;

  typedef enum logic [2:0] {
    OP_CMD   = 3'd0,
    OP_READ  = 3'd1,
    OP_OPEN  = 3'd2,
    OP_WBYTE = 3'd3,
    OP_CLOSE = 3'd4,
    OP_CARD  = 3'd5
  } op_e;

  localparam logic [1:0] KIND_BUS  = 2'd0;
  localparam logic [1:0] KIND_READ = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_ERR = 2'd1;
  localparam logic [1:0] ST_REJ = 2'd2;

  localparam logic [1:0] CFG_BLOCK_ADDR = 2'd0;
  localparam logic [1:0] CFG_RESP_TRIES = 2'd1;
  localparam logic [1:0] CFG_TOKEN_TRIES = 2'd2;
  localparam logic [1:0] CFG_BUSY_TRIES = 2'd3;

  localparam logic [7:0]  RESP_TRIES_RST  = 8'd10;
  localparam logic [15:0] TOKEN_TRIES_RST = 16'd40000;
  localparam logic [15:0] BUSY_TRIES_RST  = 16'd5000;

  localparam logic [7:0] BYTE_IDLE  = 8'hFF;
  localparam logic [7:0] TOKEN_DATA = 8'hFE;
  localparam logic [7:0] BYTE_ZERO  = 8'h00;
  localparam logic [4:0] DRESP_MASK = 5'h1F;
  localparam logic [4:0] DRESP_OK   = 5'h05;
  localparam logic [5:0] CMD_APP    = 6'd55;
  localparam logic [5:0] CMD_READ   = 6'd17;
  localparam logic [5:0] CMD_WRITE  = 6'd24;

  typedef struct packed {
    logic        block_addr;
    logic [7:0]  resp_tries;
    logic [15:0] token_tries;
    logic [15:0] busy_tries;
  } cfg_t;

  typedef struct packed {
    op_e         op;
    logic [5:0]  cmd;
    logic        app;
    logic [31:0] arg;
    logic [8:0]  off;
    logic [9:0]  cnt;
    logic        bad_range;
    logic [7:0]  data;
    logic [7:0]  miso;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] mosi;
    logic       cs;
    logic [7:0] rbyte;
    logic [1:0] status;
    logic [7:0] resp;
    logic       last;
  } res_t;

  // Fixed CRC for the frame tail; only CMD0 and CMD8 need a real one
  function automatic logic [7:0] frame_crc(input logic [5:0] cmd);
    logic [7:0] crc;
    case (cmd)
      6'd0:    crc = 8'h95;
      6'd8:    crc = 8'h87;
      default: crc = 8'h01;
    endcase
    return crc;
  endfunction

endpackage

### rtl/sdspi_front.sv
module sdspi_front
  import sdspi_pkg::*;
#(
  parameter int unsigned BlockBytes = BLOCK_BYTES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  opcode_i,
  input  logic [5:0]  cmd_index_i,
  input  logic        app_cmd_i,
  input  logic [31:0] argument_i,
  input  logic [8:0]  offset_i,
  input  logic [9:0]  count_i,
  input  logic [7:0]  data_byte_i,
  input  logic [7:0]  miso_byte_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  qstat_t      q_stat_i,
  output logic        q_push_o,
  output item_t       q_item_o,
  output cfg_t        cfg_o
);

  cfg_t        cfg_q, cfg_d;
  logic [31:0] sector_addr;
  logic [31:0] range_end;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = q_stat_i.full;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_BLOCK_ADDR:  cfg_d.block_addr  = cfg_data_i[0];
        CFG_RESP_TRIES:  cfg_d.resp_tries  = cfg_data_i[7:0];
        CFG_TOKEN_TRIES: cfg_d.token_tries = cfg_data_i;
        CFG_BUSY_TRIES:  cfg_d.busy_tries  = cfg_data_i;
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{block_addr: 1'b0, resp_tries: RESP_TRIES_RST,
                 token_tries: TOKEN_TRIES_RST, busy_tries: BUSY_TRIES_RST};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

  // Byte addressing wraps modulo 2^32
  assign sector_addr = cfg_q.block_addr ? argument_i : argument_i * 32'(BlockBytes);
  assign range_end   = 32'(offset_i) + 32'(count_i);

  always_comb begin
    q_item_o.op        = op_e'(opcode_i);
    q_item_o.cmd       = cmd_index_i;
    q_item_o.app       = app_cmd_i;
    q_item_o.arg       = (opcode_i == OP_CMD) ? argument_i : sector_addr;
    q_item_o.off       = offset_i;
    q_item_o.cnt       = count_i;
    q_item_o.bad_range = (count_i == 10'd0) || (range_end > 32'(BlockBytes));
    q_item_o.data      = data_byte_i;
    q_item_o.miso      = miso_byte_i;
  end

  // Drop undefined opcodes here, they never reach the back end
  assign q_push_o = in_valid_i && !q_stat_i.full && (opcode_i <= OP_CARD);

endmodule

### rtl/sdspi_queue.sv
module sdspi_queue
  import sdspi_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  item_t  item_i,
  input  logic   pop_i,
  output item_t  item_o,
  output qstat_t stat_o
);

  item_t      mem_q [2];
  logic       wp_q, wp_d, rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;

  always_comb begin
    wp_d  = wp_q ^ push_i;
    rp_d  = rp_q ^ pop_i;
    cnt_d = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= item_i;
    end
  end

  assign item_o       = mem_q[rp_q];
  assign stat_o.full  = cnt_q == 2'd2;
  assign stat_o.empty = cnt_q == 2'd0;

endmodule

### rtl/sdspi_back.sv
module sdspi_back
  import sdspi_pkg::*;
#(
  parameter int unsigned BlockBytes = BLOCK_BYTES
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  cfg_t   cfg_i,
  input  qstat_t q_stat_i,
  input  item_t  item_i,
  output logic   q_pop_o,
  output logic   out_valid_o,
  input  logic   out_stall_i,
  output res_t   res_o
);

  localparam int unsigned CW = $clog2(BlockBytes + 3);

  typedef enum logic [15:0] {
    PH_IDLE    = 16'h0001,
    PH_DESEL   = 16'h0002,
    PH_SEL     = 16'h0004,
    PH_FRAME   = 16'h0008,
    PH_R1      = 16'h0010,
    PH_TOKEN   = 16'h0020,
    PH_LEAD    = 16'h0040,
    PH_DATA    = 16'h0080,
    PH_TRAIL   = 16'h0100,
    PH_FINAL   = 16'h0200,
    PH_OPEN_FF = 16'h0400,
    PH_OPEN_FE = 16'h0800,
    PH_WBYTE   = 16'h1000,
    PH_ZERO    = 16'h2000,
    PH_DRESP   = 16'h4000,
    PH_BUSY    = 16'h8000
  } phase_e;

  typedef enum logic [2:0] {
    RQ_NONE  = 3'b000,
    RQ_CMD   = 3'b001,
    RQ_READ  = 3'b010,
    RQ_OPEN  = 3'b011,
    RQ_BYTE  = 3'b100,
    RQ_CLOSE = 3'b101
  } req_e;

  phase_e      phase_q, phase_d;
  req_e        req_q, req_d;
  logic [CW-1:0] bc_q, bc_d, wrem_q, wrem_d, roff_q, roff_d, rcnt_q, rcnt_d;
  logic [15:0] poll_q, poll_d;
  logic [5:0]  fcmd_q, fcmd_d;
  logic [31:0] farg_q, farg_d;
  logic        app_q, app_d, sel_q, sel_d, fst_q, fst_d;
  logic [7:0]  resp_q, resp_d;

  logic          go;
  logic [7:0]    b;
  logic [CW-1:0] bc_dec;
  logic [7:0]    r1_left;
  logic [15:0]   poll_dec;
  logic [5:0]    eff_cmd;
  logic [31:0]   eff_arg;
  logic          v0, v1;
  res_t          r0, r1;

  res_t          ofifo_q [4];
  logic [1:0]    owp_q, owp_d, orp_q, orp_d;
  logic [2:0]    ocnt_q, ocnt_d;
  logic          opop;

  // Take an item only with room for the widest burst of two results
  assign go      = !q_stat_i.empty && (ocnt_q <= 3'd2);
  assign q_pop_o = go;
  assign b       = item_i.miso;
  assign bc_dec  = (bc_q != '0) ? bc_q - CW'(1) : bc_q;
  assign r1_left = poll_q[7:0] - 8'd1;
  assign poll_dec = poll_q - 16'd1;

  assign eff_cmd = app_q ? CMD_APP : fcmd_q;
  assign eff_arg = app_q ? 32'd0 : farg_q;

  always_comb begin
    phase_d = phase_q;
    req_d   = req_q;
    bc_d    = bc_q;
    wrem_d  = wrem_q;
    roff_d  = roff_q;
    rcnt_d  = rcnt_q;
    poll_d  = poll_q;
    fcmd_d  = fcmd_q;
    farg_d  = farg_q;
    app_d   = app_q;
    sel_d   = sel_q;
    fst_d   = fst_q;
    resp_d  = resp_q;
    v0 = 1'b0;
    v1 = 1'b0;
    r0 = '0;
    r1 = '0;
    r0.kind = KIND_BUS;
    r0.mosi = BYTE_IDLE;
    r1.kind = KIND_BUS;
    r1.mosi = BYTE_IDLE;

    if (go) begin
      if (item_i.op != OP_CARD) begin
        v0 = 1'b1;
        if (phase_q != PH_IDLE) begin
          r0.kind   = KIND_DONE;
          r0.mosi   = BYTE_ZERO;
          r0.status = ST_REJ;
        end else begin
          case (item_i.op)
            OP_CMD, OP_READ, OP_OPEN: begin
              if (item_i.op == OP_READ && item_i.bad_range) begin
                r0.kind   = KIND_DONE;
                r0.mosi   = BYTE_ZERO;
                r0.status = ST_ERR;
              end else begin
                sel_d   = 1'b0;
                phase_d = PH_DESEL;
                farg_d  = item_i.arg;
                case (item_i.op)
                  OP_CMD: begin
                    req_d  = RQ_CMD;
                    fcmd_d = item_i.cmd;
                    app_d  = item_i.app;
                  end
                  OP_READ: begin
                    req_d  = RQ_READ;
                    fcmd_d = CMD_READ;
                    app_d  = 1'b0;
                    roff_d = CW'(item_i.off);
                    rcnt_d = CW'(item_i.cnt);
                  end
                  default: begin
                    req_d  = RQ_OPEN;
                    fcmd_d = CMD_WRITE;
                    app_d  = 1'b0;
                  end
                endcase
              end
            end
            OP_WBYTE: begin
              if (wrem_q == '0) begin
                r0.kind = KIND_DONE;
                r0.mosi = BYTE_ZERO;
              end else begin
                wrem_d  = wrem_q - CW'(1);
                req_d   = RQ_BYTE;
                phase_d = PH_WBYTE;
                r0.mosi = item_i.data;
              end
            end
            default: begin
              bc_d    = wrem_q + CW'(2);
              wrem_d  = '0;
              req_d   = RQ_CLOSE;
              phase_d = PH_ZERO;
              r0.mosi = BYTE_ZERO;
            end
          endcase
        end
      end else begin
        v0 = phase_q != PH_IDLE;
        case (phase_q)
          PH_DESEL: begin
            sel_d   = 1'b1;
            phase_d = PH_SEL;
          end
          PH_SEL: begin
            bc_d    = '0;
            phase_d = PH_FRAME;
            r0.mosi = {2'b01, eff_cmd};
          end
          PH_FRAME: begin
            if (bc_q < CW'(5)) begin
              bc_d = bc_q + CW'(1);
              case (bc_q[2:0])
                3'd0:    r0.mosi = eff_arg[31:24];
                3'd1:    r0.mosi = eff_arg[23:16];
                3'd2:    r0.mosi = eff_arg[15:8];
                3'd3:    r0.mosi = eff_arg[7:0];
                default: r0.mosi = frame_crc(eff_cmd);
              endcase
            end else begin
              poll_d  = {8'd0, cfg_i.resp_tries};
              phase_d = PH_R1;
            end
          end
          PH_R1: begin
            if (b[7]) begin
              poll_d = {8'd0, r1_left};
            end
            if (!b[7] || r1_left == 8'd0) begin
              resp_d = b;
              if (app_q) begin
                app_d = 1'b0;
                if (b > 8'd1) begin
                  phase_d   = PH_IDLE;
                  req_d     = RQ_NONE;
                  r0.kind   = KIND_DONE;
                  r0.mosi   = BYTE_ZERO;
                  r0.status = ST_ERR;
                end else begin
                  sel_d   = 1'b0;
                  phase_d = PH_DESEL;
                end
              end else if (req_q == RQ_READ) begin
                if (b != 8'd0) begin
                  fst_d   = 1'b1;
                  sel_d   = 1'b0;
                  phase_d = PH_FINAL;
                end else begin
                  poll_d  = cfg_i.token_tries;
                  phase_d = PH_TOKEN;
                end
              end else if (req_q == RQ_OPEN && b == 8'd0) begin
                phase_d = PH_OPEN_FF;
              end else begin
                phase_d   = PH_IDLE;
                req_d     = RQ_NONE;
                r0.kind   = KIND_DONE;
                r0.mosi   = BYTE_ZERO;
                r0.status = (req_q == RQ_OPEN || b[7]) ? ST_ERR : ST_OK;
              end
            end
          end
          PH_TOKEN: begin
            if (b == BYTE_IDLE) begin
              poll_d = poll_dec;
              if (poll_dec == 16'd0) begin
                fst_d   = 1'b1;
                sel_d   = 1'b0;
                phase_d = PH_FINAL;
              end
            end else if (b == TOKEN_DATA) begin
              if (roff_q != '0) begin
                bc_d    = roff_q;
                phase_d = PH_LEAD;
              end else begin
                bc_d    = rcnt_q;
                phase_d = PH_DATA;
              end
            end else begin
              fst_d   = 1'b1;
              sel_d   = 1'b0;
              phase_d = PH_FINAL;
            end
          end
          PH_LEAD: begin
            bc_d = bc_dec;
            if (bc_dec == '0) begin
              bc_d    = rcnt_q;
              phase_d = PH_DATA;
            end
          end
          PH_DATA: begin
            // Hand the byte to the host, then clock the next one
            v1       = 1'b1;
            r0.kind  = KIND_READ;
            r0.mosi  = BYTE_ZERO;
            r0.rbyte = b;
            r0.last  = bc_q <= CW'(1);
            bc_d     = bc_dec;
            if (bc_dec == '0) begin
              bc_d    = CW'(BlockBytes + 2) - roff_q - rcnt_q;
              phase_d = PH_TRAIL;
            end
          end
          PH_TRAIL: begin
            bc_d = bc_dec;
            if (bc_dec == '0) begin
              fst_d   = 1'b0;
              sel_d   = 1'b0;
              phase_d = PH_FINAL;
            end
          end
          PH_FINAL: begin
            phase_d   = PH_IDLE;
            req_d     = RQ_NONE;
            r0.kind   = KIND_DONE;
            r0.mosi   = BYTE_ZERO;
            r0.status = fst_q ? ST_ERR : ST_OK;
          end
          PH_OPEN_FF: begin
            phase_d = PH_OPEN_FE;
            r0.mosi = TOKEN_DATA;
          end
          PH_OPEN_FE, PH_WBYTE: begin
            if (phase_q == PH_OPEN_FE) begin
              wrem_d = CW'(BlockBytes);
            end
            phase_d = PH_IDLE;
            req_d   = RQ_NONE;
            r0.kind = KIND_DONE;
            r0.mosi = BYTE_ZERO;
          end
          PH_ZERO: begin
            bc_d = bc_dec;
            if (bc_dec != '0) begin
              r0.mosi = BYTE_ZERO;
            end else begin
              phase_d = PH_DRESP;
            end
          end
          PH_DRESP: begin
            if ((b[4:0] & DRESP_MASK) == DRESP_OK) begin
              poll_d  = cfg_i.busy_tries;
              phase_d = PH_BUSY;
            end else begin
              phase_d   = PH_IDLE;
              req_d     = RQ_NONE;
              r0.kind   = KIND_DONE;
              r0.mosi   = BYTE_ZERO;
              r0.status = ST_ERR;
            end
          end
          PH_BUSY: begin
            if (b != BYTE_IDLE && poll_q != 16'd0) begin
              poll_d = poll_dec;
            end else begin
              fst_d   = poll_q == 16'd0;
              sel_d   = 1'b0;
              phase_d = PH_FINAL;
            end
          end
          default: begin
            phase_d = PH_IDLE;
            req_d   = RQ_NONE;
          end
        endcase
      end
    end
    r0.cs   = sel_d;
    r0.resp = resp_d;
    r1.cs   = sel_d;
    r1.resp = resp_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      req_q   <= RQ_NONE;
      bc_q    <= '0;
      wrem_q  <= '0;
      roff_q  <= '0;
      rcnt_q  <= '0;
      poll_q  <= '0;
      fcmd_q  <= '0;
      farg_q  <= '0;
      app_q   <= 1'b0;
      sel_q   <= 1'b0;
      fst_q   <= 1'b0;
      resp_q  <= BYTE_IDLE;
    end else begin
      phase_q <= phase_d;
      req_q   <= req_d;
      bc_q    <= bc_d;
      wrem_q  <= wrem_d;
      roff_q  <= roff_d;
      rcnt_q  <= rcnt_d;
      poll_q  <= poll_d;
      fcmd_q  <= fcmd_d;
      farg_q  <= farg_d;
      app_q   <= app_d;
      sel_q   <= sel_d;
      fst_q   <= fst_d;
      resp_q  <= resp_d;
    end
  end

  // Result queue
  assign opop = out_valid_o && !out_stall_i;

  always_comb begin
    owp_d  = owp_q + {1'b0, v0} + {1'b0, v1};
    orp_d  = orp_q + {1'b0, opop};
    ocnt_d = ocnt_q + {2'b0, v0} + {2'b0, v1} - {2'b0, opop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owp_q  <= '0;
      orp_q  <= '0;
      ocnt_q <= '0;
    end else begin
      owp_q  <= owp_d;
      orp_q  <= orp_d;
      ocnt_q <= ocnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v0) begin
      ofifo_q[owp_q] <= r0;
    end
    if (v1) begin
      ofifo_q[owp_q + 2'd1] <= r1;
    end
  end

  assign out_valid_o = ocnt_q != 3'd0;
  assign res_o       = ofifo_q[orp_q];

endmodule

### rtl/sd_spi_command_engine.sv
// Channel   Direction  Handshake                Payload
// in        input      in_valid_i / in_stall_o  opcode .. miso_byte
// out       output     out_valid_o / out_stall_i kind .. last
// cfg       input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One item a cycle unless stalled: the front end registers each item into a
// two-entry queue, the back end retires one queued item a cycle into a four-entry
// result queue, and the result is registered there before it shows at the output.
// The back end waits while fewer than two result slots are free.
// Reset is asynchronous, active low; the card starts deselected, no request open.
`include "sd_spi_command_engine_defines.svh"

module sd_spi_command_engine
  import sdspi_pkg::*;
#(
  parameter int unsigned BlockBytes = BLOCK_BYTES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  opcode_i,
  input  logic [5:0]  cmd_index_i,
  input  logic        app_cmd_i,
  input  logic [31:0] argument_i,
  input  logic [8:0]  offset_i,
  input  logic [9:0]  count_i,
  input  logic [7:0]  data_byte_i,
  input  logic [7:0]  miso_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  mosi_byte_o,
  output logic        chip_select_o,
  output logic [7:0]  read_byte_o,
  output logic [1:0]  status_o,
  output logic [7:0]  response_o,
  output logic        last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  qstat_t q_stat;
  logic   q_push, q_pop;
  item_t  q_in, q_out;
  cfg_t   cfg;
  res_t   res;

  sdspi_front #(
    .BlockBytes(BlockBytes)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .opcode_i   (opcode_i),
    .cmd_index_i(cmd_index_i),
    .app_cmd_i  (app_cmd_i),
    .argument_i (argument_i),
    .offset_i   (offset_i),
    .count_i    (count_i),
    .data_byte_i(data_byte_i),
    .miso_byte_i(miso_byte_i),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .q_stat_i   (q_stat),
    .q_push_o   (q_push),
    .q_item_o   (q_in),
    .cfg_o      (cfg)
  );

  sdspi_queue u_queue (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(q_push),
    .item_i(q_in),
    .pop_i (q_pop),
    .item_o(q_out),
    .stat_o(q_stat)
  );

  sdspi_back #(
    .BlockBytes(BlockBytes)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .q_stat_i   (q_stat),
    .item_i     (q_out),
    .q_pop_o    (q_pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .res_o      (res)
  );

  assign kind_o        = res.kind;
  assign mosi_byte_o   = res.mosi;
  assign chip_select_o = res.cs;
  assign read_byte_o   = res.rbyte;
  assign status_o      = res.status;
  assign response_o    = res.resp;
  assign last_o        = res.last;

  `SDSPI_ASSERT(a_pop_has_item, q_pop |-> !q_stat.empty)
  `SDSPI_ASSERT_NEXT(a_push_lands, q_push, !q_stat.empty)
  `SDSPI_ASSERT(a_read_selected, (out_valid_o && kind_o == KIND_READ) |-> chip_select_o)
  `SDSPI_ASSERT(a_status_on_done, (out_valid_o && kind_o != KIND_DONE) |-> status_o == ST_OK)

endmodule

### test/tb_sd_spi_command_engine.sv
module tb_sd_spi_command_engine;
  timeunit 1ns;
  timeprecision 1ps;

  import sdspi_pkg::*;

  typedef enum int {
    PH_IDLE, PH_DESEL, PH_SEL, PH_FRAME, PH_R1, PH_TOKEN, PH_LEAD, PH_DATA,
    PH_TRAIL, PH_FINAL, PH_OPEN_FF, PH_OPEN_FE, PH_WBYTE, PH_ZERO, PH_DRESP, PH_BUSY
  } phase_e;

  typedef enum int {RQ_NONE, RQ_CMD, RQ_READ, RQ_OPEN, RQ_BYTE, RQ_CLOSE} req_e;

  typedef struct {
    logic [2:0]  op;
    logic [5:0]  cmd;
    logic        app;
    logic [31:0] arg;
    logic [8:0]  off;
    logic [9:0]  cnt;
    logic [7:0]  data;
    logic [7:0]  miso;
  } stim_t;

  class engine_scoreboard;
    bit          blk;
    bit [7:0]    rtries;
    bit [15:0]   ttries, btries;
    phase_e      phase;
    int unsigned bcnt, wrem, roff, rcnt;
    bit [15:0]   pcnt;
    bit [5:0]    fcmd;
    bit [31:0]   farg;
    bit          app_pend, sel;
    bit [7:0]    lresp;
    req_e        preq;
    bit [1:0]    fstat;
    res_t        expq[$];
    int          errors;

    function new();
      blk = 0; rtries = RESP_TRIES_RST; ttries = TOKEN_TRIES_RST; btries = BUSY_TRIES_RST;
      phase = PH_IDLE; bcnt = 0; wrem = 0; roff = 0; rcnt = 0; pcnt = 0; fcmd = 0;
      farg = 0; app_pend = 0; sel = 0; lresp = BYTE_IDLE; preq = RQ_NONE; fstat = ST_OK;
      errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        CFG_BLOCK_ADDR:  blk = val[0];
        CFG_RESP_TRIES:  rtries = val[7:0];
        CFG_TOKEN_TRIES: ttries = val;
        CFG_BUSY_TRIES:  btries = val;
        default: ;
      endcase
    endfunction

    function void put(logic [1:0] k, logic [7:0] mosi, logic [7:0] rb, logic [1:0] st,
                      logic lst);
      res_t r;
      r.kind = k; r.mosi = mosi; r.cs = sel; r.rbyte = rb;
      r.status = st; r.resp = lresp; r.last = lst;
      expq.push_back(r);
    endfunction

    function void bus(logic [7:0] mosi);
      put(KIND_BUS, mosi, 8'h00, ST_OK, 1'b0);
    endfunction

    function void finish(logic [1:0] st);
      phase = PH_IDLE;
      preq = RQ_NONE;
      put(KIND_DONE, 8'h00, 8'h00, st, 1'b0);
    endfunction

    function logic [7:0] frame_byte(int unsigned k);
      logic [5:0]  c;
      logic [31:0] a;
      c = app_pend ? CMD_APP : fcmd;
      a = app_pend ? 32'h0 : farg;
      if (k == 0) return {2'b01, c};
      if (k < 5) return 8'(a >> (8 * (4 - k)));
      if (c == 6'd0) return 8'h95;
      if (c == 6'd8) return 8'h87;
      return 8'h01;
    endfunction

    function void start_frame();
      sel = 0;
      phase = PH_DESEL;
      bus(BYTE_IDLE);
    endfunction

    function void deselect_end(logic [1:0] st);
      fstat = st;
      sel = 0;
      phase = PH_FINAL;
      bus(BYTE_IDLE);
    endfunction

    function logic [31:0] sector_addr(logic [31:0] s);
      return blk ? s : s * 32'(BLOCK_BYTES);
    endfunction

    function void r1_done(logic [7:0] r1);
      if (app_pend) begin
        app_pend = 0;
        if (r1 > 8'd1) finish(ST_ERR);
        else start_frame();
      end else if (preq == RQ_READ) begin
        if (r1 != 0) deselect_end(ST_ERR);
        else begin
          pcnt = ttries;
          phase = PH_TOKEN;
          bus(BYTE_IDLE);
        end
      end else if (preq == RQ_OPEN) begin
        if (r1 != 0) finish(ST_ERR);
        else begin
          phase = PH_OPEN_FF;
          bus(BYTE_IDLE);
        end
      end else begin
        finish(r1[7] ? ST_ERR : ST_OK);
      end
    endfunction

    function void card_byte(logic [7:0] b);
      case (phase)
        PH_DESEL: begin sel = 1; phase = PH_SEL; bus(BYTE_IDLE); end
        PH_SEL: begin bcnt = 0; phase = PH_FRAME; bus(frame_byte(0)); end
        PH_FRAME: begin
          if (bcnt < 5) begin
            bcnt++;
            bus(frame_byte(bcnt));
          end else begin
            pcnt = {8'h00, rtries};
            phase = PH_R1;
            bus(BYTE_IDLE);
          end
        end
        PH_R1: begin
          if (b[7]) pcnt = {8'h00, pcnt[7:0] - 8'd1};
          if (!b[7] || pcnt == 0) begin
            lresp = b;
            r1_done(b);
          end else bus(BYTE_IDLE);
        end
        PH_TOKEN: begin
          if (b == BYTE_IDLE) begin
            pcnt = pcnt - 16'd1;
            if (pcnt == 0) deselect_end(ST_ERR);
            else bus(BYTE_IDLE);
          end else if (b == TOKEN_DATA) begin
            if (roff != 0) begin bcnt = roff; phase = PH_LEAD; end
            else begin bcnt = rcnt; phase = PH_DATA; end
            bus(BYTE_IDLE);
          end else deselect_end(ST_ERR);
        end
        PH_LEAD: begin
          if (bcnt != 0) bcnt--;
          if (bcnt == 0) begin bcnt = rcnt; phase = PH_DATA; end
          bus(BYTE_IDLE);
        end
        PH_DATA: begin
          put(KIND_READ, 8'h00, b, ST_OK, bcnt <= 1);
          if (bcnt != 0) bcnt--;
          if (bcnt == 0) begin
            bcnt = BLOCK_BYTES + 2 - roff - rcnt;
            phase = PH_TRAIL;
          end
          bus(BYTE_IDLE);
        end
        PH_TRAIL: begin
          if (bcnt != 0) bcnt--;
          if (bcnt == 0) deselect_end(ST_OK);
          else bus(BYTE_IDLE);
        end
        PH_FINAL: finish(fstat);
        PH_OPEN_FF: begin phase = PH_OPEN_FE; bus(TOKEN_DATA); end
        PH_OPEN_FE: begin wrem = BLOCK_BYTES; finish(ST_OK); end
        PH_WBYTE: finish(ST_OK);
        PH_ZERO: begin
          if (bcnt != 0) bcnt--;
          if (bcnt != 0) bus(BYTE_ZERO);
          else begin phase = PH_DRESP; bus(BYTE_IDLE); end
        end
        PH_DRESP: begin
          if (b[4:0] == DRESP_OK) begin
            pcnt = btries;
            phase = PH_BUSY;
            bus(BYTE_IDLE);
          end else finish(ST_ERR);
        end
        PH_BUSY: begin
          if (b != BYTE_IDLE && pcnt != 0) begin
            pcnt--;
            bus(BYTE_IDLE);
          end else deselect_end(pcnt != 0 ? ST_OK : ST_ERR);
        end
        default: begin phase = PH_IDLE; preq = RQ_NONE; end
      endcase
    endfunction

    function void note_item(stim_t s);
      if (s.op > OP_CARD) return;
      if (s.op == OP_CARD) begin
        if (phase != PH_IDLE) card_byte(s.miso);
        return;
      end
      if (phase != PH_IDLE) begin
        put(KIND_DONE, 8'h00, 8'h00, ST_REJ, 1'b0);
        return;
      end
      case (s.op)
        OP_CMD: begin
          preq = RQ_CMD; fcmd = s.cmd; farg = s.arg; app_pend = s.app;
          start_frame();
        end
        OP_READ: begin
          if (s.cnt == 0 || int'(s.off) + int'(s.cnt) > BLOCK_BYTES) finish(ST_ERR);
          else begin
            roff = s.off; rcnt = s.cnt; preq = RQ_READ;
            fcmd = CMD_READ; farg = sector_addr(s.arg); app_pend = 0;
            start_frame();
          end
        end
        OP_OPEN: begin
          preq = RQ_OPEN; fcmd = CMD_WRITE; farg = sector_addr(s.arg); app_pend = 0;
          start_frame();
        end
        OP_WBYTE: begin
          if (wrem == 0) finish(ST_OK);
          else begin
            wrem--;
            preq = RQ_BYTE;
            phase = PH_WBYTE;
            bus(s.data);
          end
        end
        default: begin
          bcnt = wrem + 2;
          wrem = 0;
          preq = RQ_CLOSE;
          phase = PH_ZERO;
          bus(BYTE_ZERO);
        end
      endcase
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check(res_t g);
      res_t e;
      if (expq.size() == 0) begin
        report($sformatf("result with nothing pending, kind %0d", g.kind));
        return;
      end
      e = expq.pop_front();
      if (g.kind !== e.kind) report($sformatf("kind %0d, want %0d", g.kind, e.kind));
      if (g.mosi !== e.mosi) report($sformatf("mosi %h, want %h", g.mosi, e.mosi));
      if (g.cs !== e.cs) report($sformatf("chip select %b, want %b", g.cs, e.cs));
      if (g.rbyte !== e.rbyte) report($sformatf("read byte %h, want %h", g.rbyte, e.rbyte));
      if (g.status !== e.status) report($sformatf("status %0d, want %0d", g.status, e.status));
      if (g.resp !== e.resp) report($sformatf("response %h, want %h", g.resp, e.resp));
      if (g.last !== e.last) report($sformatf("last %b, want %b", g.last, e.last));
    endtask
  endclass

  logic        clk_i, rst_ni;
  logic        in_valid_i, in_stall_o;
  logic [2:0]  opcode_i;
  logic [5:0]  cmd_index_i;
  logic        app_cmd_i;
  logic [31:0] argument_i;
  logic [8:0]  offset_i;
  logic [9:0]  count_i;
  logic [7:0]  data_byte_i, miso_byte_i;
  logic        out_valid_o, out_stall_i;
  logic [1:0]  kind_o;
  logic [7:0]  mosi_byte_o;
  logic        chip_select_o;
  logic [7:0]  read_byte_o;
  logic [1:0]  status_o;
  logic [7:0]  response_o;
  logic        last_o;
  logic        cfg_valid_i, cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [15:0] cfg_data_i;

  engine_scoreboard sb;
  bit hold_off;
  bit no_gaps;

  sd_spi_command_engine DUT (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #30ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic int draw_gap();
    if (no_gaps) return 0;
    return $urandom_range(0, 10);
  endfunction

  function automatic stim_t rand_stim(logic [2:0] op);
    stim_t s;
    s.op = op; s.cmd = 6'($urandom_range(0, 63)); s.app = 1'($urandom_range(0, 1));
    s.arg = $urandom; s.off = 9'($urandom_range(0, 511));
    s.cnt = 10'($urandom_range(0, 1023));
    s.data = 8'($urandom_range(0, 255)); s.miso = 8'($urandom_range(0, 255));
    return s;
  endfunction

  task automatic send(stim_t s);
    int  g;
    bit  st;
    g = draw_gap();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= s.op; cmd_index_i <= s.cmd; app_cmd_i <= s.app; argument_i <= s.arg;
    offset_i <= s.off; count_i <= s.cnt; data_byte_i <= s.data; miso_byte_i <= s.miso;
    do begin
      @(negedge clk_i);
      st = in_stall_o;
      @(posedge clk_i);
    end while (st);
    sb.note_item(s);
  endtask

  // Reply as a card would, mostly well formed
  function automatic logic [7:0] card_reply();
    int r;
    r = $urandom_range(0, 99);
    case (sb.phase)
      PH_R1: begin
        if (sb.app_pend) return r < 80 ? 8'($urandom_range(0, 1)) : 8'($urandom_range(0, 255));
        if (r < 75) return 8'h00;
        if (r < 85) return 8'($urandom_range(0, 127));
        return 8'($urandom_range(128, 255));
      end
      PH_TOKEN: return r < 55 ? BYTE_IDLE : r < 93 ? TOKEN_DATA : 8'($urandom_range(0, 253));
      PH_DRESP: return r < 85 ? {3'($urandom_range(0, 7)), DRESP_OK} : 8'($urandom_range(0, 255));
      PH_BUSY: return r < 65 ? 8'($urandom_range(0, 254)) : BYTE_IDLE;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Issue one request and play the card until the engine is idle again
  task automatic request(stim_t s);
    stim_t c;
    int    r;
    send(s);
    while (sb.phase != PH_IDLE) begin
      r = $urandom_range(0, 99);
      if (r < 4) c = rand_stim(3'($urandom_range(OP_CMD, OP_CLOSE)));
      else if (r < 6) c = rand_stim(3'($urandom_range(6, 7)));
      else begin
        c = rand_stim(OP_CARD);
        c.miso = card_reply();
      end
      send(c);
    end
  endtask

  // Hold the input idle while everything outstanding comes back
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.expq.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    bit rdy;
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do begin
      @(negedge clk_i);
      rdy = cfg_ready_o;
      @(posedge clk_i);
    end while (!rdy);
    sb.write_reg(idx, val);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_regs(logic ba, logic [7:0] rt, logic [15:0] tt, logic [15:0] bt);
    write_reg(CFG_BLOCK_ADDR, {15'h0, ba});
    write_reg(CFG_RESP_TRIES, {8'h00, rt});
    write_reg(CFG_TOKEN_TRIES, tt);
    write_reg(CFG_BUSY_TRIES, bt);
  endtask

  task automatic write_session(int nbytes);
    request(rand_stim(OP_OPEN));
    repeat (nbytes) request(rand_stim(OP_WBYTE));
    request(rand_stim(OP_CLOSE));
  endtask

  task automatic random_requests(int n);
    stim_t s;
    int    r;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 7) == 0) no_gaps = ~no_gaps;
      if (r < 30) request(rand_stim(OP_CMD));
      else if (r < 50) begin
        s = rand_stim(OP_READ);
        if ($urandom_range(0, 9) < 7) begin
          s.off = 9'($urandom_range(0, 511));
          s.cnt = 10'($urandom_range(1, 512 - s.off));
        end
        request(s);
      end else if (r < 80) begin
        write_session($urandom_range(0, 29) == 0 ? 514 : $urandom_range(0, 6));
      end else if (r < 90) request(rand_stim(3'($urandom_range(OP_WBYTE, OP_CLOSE))));
      else request(rand_stim(3'($urandom_range(OP_CARD, 7))));
    end
  endtask

  task automatic directed();
    stim_t s;
    send(rand_stim(OP_CARD));
    send(rand_stim(3'd6));
    send(rand_stim(3'd7));
    s = rand_stim(OP_CMD); s.cmd = 6'd0; s.app = 0; s.arg = 32'h0; request(s);
    s = rand_stim(OP_CMD); s.cmd = 6'd8; s.app = 0; s.arg = 32'h1AA; request(s);
    s = rand_stim(OP_CMD); s.cmd = 6'd63; s.app = 0; s.arg = 32'hFFFF_FFFF; request(s);
    s = rand_stim(OP_CMD); s.cmd = 6'd41; s.app = 1; s.arg = 32'h4000_0000; request(s);
    request(rand_stim(OP_WBYTE));
    request(rand_stim(OP_CLOSE));
    s = rand_stim(OP_READ); s.off = 0; s.cnt = 0; request(s);
    s = rand_stim(OP_READ); s.off = 511; s.cnt = 2; request(s);
    s = rand_stim(OP_READ); s.off = 0; s.cnt = 512; request(s);
    s = rand_stim(OP_READ); s.off = 511; s.cnt = 1; request(s);
    s = rand_stim(OP_READ); s.off = 9'h1FF; s.cnt = 10'h3FF; request(s);
    write_session(2);
  endtask

  initial begin
    res_t got;
    int   g;
    bit   v;
    out_stall_i <= 1'b1;
    @(posedge rst_ni);
    forever begin
      if (hold_off) begin
        out_stall_i <= 1'b1;
        repeat (400) @(posedge clk_i);
        hold_off = 0;
      end
      g = draw_gap();
      if (g > 0) begin
        out_stall_i <= 1'b1;
        repeat (g) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do begin
        @(negedge clk_i);
        v = out_valid_o;
        got.kind = kind_o; got.mosi = mosi_byte_o; got.cs = chip_select_o;
        got.rbyte = read_byte_o; got.status = status_o; got.resp = response_o;
        got.last = last_o;
        @(posedge clk_i);
      end while (!v);
      sb.check(got);
    end
  end

  initial begin
    sb = new();
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0; opcode_i <= '0; cmd_index_i <= '0; app_cmd_i <= 1'b0;
    argument_i <= '0; offset_i <= '0; count_i <= '0; data_byte_i <= '0; miso_byte_i <= '0;
    cfg_valid_i <= 1'b0; cfg_index_i <= '0; cfg_data_i <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed();
    random_requests(8);

    set_regs(1'b1, 8'd1, 16'd1, 16'd1);
    hold_off = 1;
    random_requests(12);

    // pause the sender until everything outstanding has come back
    drain();
    set_regs(1'b0, 8'd255, 16'd65535, 16'd65535);
    random_requests(12);

    set_regs(1'b1, 8'd0, 16'd3, 16'd0);
    random_requests(10);

    set_regs(1'($urandom_range(0, 1)), 8'($urandom_range(1, 20)),
             16'($urandom_range(1, 8)), 16'($urandom_range(1, 8)));
    random_requests(12);

    drain();
    if (sb.errors == 0 && sb.expq.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
